[rtl/tipg_pkg.sv]
// Package: shared types, constants and helpers for the tape pulse generator.
`timescale 1ns / 1ps
`default_nettype none
package tipg_pkg;

   localparam logic [3:0] HEADER_SKIP = 4'd10;
   localparam int QDEPTH = 4;

   localparam logic [2:0] ACT_TOGGLE = 3'd0;
   localparam logic [2:0] ACT_HIGH   = 3'd1;
   localparam logic [2:0] ACT_LOW    = 3'd2;
   localparam logic [2:0] ACT_STOP   = 3'd4;

   localparam logic [1:0] PH_FIELDS = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_SKIP   = 2'd2;
   localparam logic [1:0] PH_PEEK   = 2'd3;

   // Work command built by the parser, expanded into results by the emitter.
   typedef struct packed {
      logic        lead_en;    // standard pilot + two syncs
      logic        lead_long;  // 8063 pilot pulses
      logic        tone_en;    // pilot/tone with explicit timing
      logic [15:0] tone_t;
      logic [15:0] tone_n;
      logic        sync_en;    // turbo syncs
      logic [15:0] sync1_t;
      logic [15:0] sync2_t;
      logic        pulse_en;   // single pulse (sequence)
      logic [15:0] pulse_t;
      logic [3:0]  nbits;      // data bits to emit, MSB first
      logic [1:0]  bit_mode;   // 0 std, 1 turbo/pure, 2 direct
      logic [7:0]  data;
      logic [15:0] zero_t;
      logic [15:0] one_t;
      logic        pause_en;
      logic [15:0] pause_len;
      logic        level_en;
      logic        level_high;
      logic        stop_en;    // stop command in the block
      logic        eof;        // trailing toggle + stop
   } cmd_type;

   localparam logic [1:0] BM_STD    = 2'd0;
   localparam logic [1:0] BM_TURBO  = 2'd1;
   localparam logic [1:0] BM_DIRECT = 2'd2;

   function automatic logic [4:0] fields_len(input logic [7:0] k);
      case (k)
         8'h10: fields_len = 5'd4;
         8'h11: fields_len = 5'd18;
         8'h12: fields_len = 5'd4;
         8'h13: fields_len = 5'd1;
         8'h14: fields_len = 5'd10;
         8'h15: fields_len = 5'd8;
         8'h20: fields_len = 5'd2;
         8'h2A: fields_len = 5'd4;
         8'h2B: fields_len = 5'd5;
         8'h31: fields_len = 5'd2;
         8'h32: fields_len = 5'd2;
         8'h35: fields_len = 5'd20;
         default: fields_len = 5'd1;
      endcase
   endfunction

   function automatic logic [3:0] norm_bits(input logic [7:0] b);
      norm_bits = (b == 8'd0 || b > 8'd8) ? 4'd8 : b[3:0];
   endfunction

endpackage
`default_nettype wire

[rtl/tipg_parser.sv]
// Front end: header skip, block parsing, builds one work command per byte.
`timescale 1ns / 1ps
`default_nettype none
module tipg_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              machine_is_48k,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_eof,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output tipg_pkg::cmd_type      cmd
);

   logic [3:0]  hdr_ff, hdr_in;
   logic [7:0]  kind_ff, kind_in;
   logic [4:0]  idx_ff, idx_in;
   logic [1:0]  ph_ff, ph_in;
   logic [15:0] pilot_t_ff, pilot_t_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [15:0] zero_ff, zero_in, one_ff, one_in, pcnt_ff, pcnt_in, pause_ff, pause_in;
   logic [3:0]  fbits_ff, fbits_in;
   logic [23:0] dleft_ff, dleft_in;
   logic [31:0] sleft_ff, sleft_in;
   logic [7:0]  low_ff, low_in, seq_ff, seq_in;
   tipg_pkg::cmd_type c;
   logic [4:0]  ni;
   logic        fire;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid;
   assign cmd       = c;
   assign fire      = in_valid & cmd_ready;

   always_comb begin
      hdr_in = hdr_ff; kind_in = kind_ff; idx_in = idx_ff; ph_in = ph_ff;
      pilot_t_in = pilot_t_ff; s1_in = s1_ff; s2_in = s2_ff; zero_in = zero_ff;
      one_in = one_ff; pcnt_in = pcnt_ff; pause_in = pause_ff; fbits_in = fbits_ff;
      dleft_in = dleft_ff; sleft_in = sleft_ff; low_in = low_ff; seq_in = seq_ff;
      c = '0;
      c.data = in_byte; c.zero_t = zero_ff; c.one_t = one_ff; c.pause_len = pause_ff;
      c.tone_t = pilot_t_ff; c.tone_n = pcnt_ff; c.sync1_t = s1_ff; c.sync2_t = s2_ff;
      c.eof = in_eof;
      ni = idx_ff + 5'd1;
      if (hdr_ff != 4'd0) begin
         hdr_in = hdr_ff - 4'd1;
      end else if (kind_ff == 8'd0 || ph_ff == tipg_pkg::PH_PEEK) begin
         if (ph_ff == tipg_pkg::PH_PEEK) begin
            c.lead_en = 1'b1; c.lead_long = (in_byte < 8'd128);
            c.pause_en = (pause_ff != 16'd0);
         end
         idx_in = '0; ph_in = tipg_pkg::PH_FIELDS; dleft_in = '0; sleft_in = '0;
         case (in_byte)
            8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h20, 8'h21, 8'h2A, 8'h2B,
            8'h30, 8'h31, 8'h32, 8'h33, 8'h35: kind_in = in_byte;
            default: kind_in = 8'd0;
         endcase
      end else if (ph_ff == tipg_pkg::PH_SKIP) begin
         sleft_in = sleft_ff - 32'd1;
         if (sleft_in == 32'd0) begin
            c.stop_en = (kind_ff == 8'h2A) && machine_is_48k;
            kind_in = '0; ph_in = tipg_pkg::PH_FIELDS; idx_in = '0;
         end
      end else if (ph_ff == tipg_pkg::PH_DATA) begin
         if (kind_ff == 8'h13) begin
            if (!idx_ff[0]) low_in = in_byte;
            else begin
               c.pulse_en = 1'b1; c.pulse_t = {in_byte, low_ff};
               seq_in = seq_ff - 8'd1;
            end
            idx_in = {4'd0, ~idx_ff[0]};
            if (idx_ff[0] && seq_in == 8'd0) begin
               kind_in = '0; ph_in = tipg_pkg::PH_FIELDS; idx_in = '0;
            end
         end else begin
            if (kind_ff == 8'h10) begin
               c.bit_mode = tipg_pkg::BM_STD; c.nbits = 4'd8;
               if (idx_ff == 5'd0) begin
                  c.lead_en = 1'b1; c.lead_long = (in_byte < 8'd128); idx_in = 5'd1;
               end
            end else begin
               c.bit_mode = (kind_ff == 8'h15) ? tipg_pkg::BM_DIRECT : tipg_pkg::BM_TURBO;
               c.nbits = (dleft_ff == 24'd1) ? fbits_ff : 4'd8;
            end
            dleft_in = dleft_ff - 24'd1;
            if (dleft_in == 24'd0) begin
               c.pause_en = (pause_ff != 16'd0);
               kind_in = '0; ph_in = tipg_pkg::PH_FIELDS; idx_in = '0;
            end
         end
      end else begin
         // field bytes
         case (kind_ff)
            8'h10: if (idx_ff < 5'd2) begin
                  if (idx_ff[0]) pause_in[15:8] = in_byte; else pause_in[7:0] = in_byte;
               end else begin
                  if (idx_ff[0]) dleft_in[15:8] = in_byte; else dleft_in[7:0] = in_byte;
               end
            8'h11: begin
               case (idx_ff)
                  5'd0: pilot_t_in[7:0] = in_byte;  5'd1: pilot_t_in[15:8] = in_byte;
                  5'd2: s1_in[7:0] = in_byte;       5'd3: s1_in[15:8] = in_byte;
                  5'd4: s2_in[7:0] = in_byte;       5'd5: s2_in[15:8] = in_byte;
                  5'd6: zero_in[7:0] = in_byte;     5'd7: zero_in[15:8] = in_byte;
                  5'd8: one_in[7:0] = in_byte;      5'd9: one_in[15:8] = in_byte;
                  5'd10: pcnt_in[7:0] = in_byte;    5'd11: pcnt_in[15:8] = in_byte;
                  5'd12: fbits_in = tipg_pkg::norm_bits(in_byte);
                  5'd13: pause_in[7:0] = in_byte;   5'd14: pause_in[15:8] = in_byte;
                  5'd15: dleft_in[7:0] = in_byte;   5'd16: dleft_in[15:8] = in_byte;
                  default: dleft_in[23:16] = in_byte;
               endcase
            end
            8'h12: if (idx_ff < 5'd2) begin
                  if (idx_ff[0]) pilot_t_in[15:8] = in_byte; else pilot_t_in[7:0] = in_byte;
               end else begin
                  if (idx_ff[0]) pcnt_in[15:8] = in_byte; else pcnt_in[7:0] = in_byte;
               end
            8'h13: seq_in = in_byte;
            8'h14: begin
               case (idx_ff)
                  5'd0: zero_in[7:0] = in_byte;  5'd1: zero_in[15:8] = in_byte;
                  5'd2: one_in[7:0] = in_byte;   5'd3: one_in[15:8] = in_byte;
                  5'd4: fbits_in = tipg_pkg::norm_bits(in_byte);
                  5'd5: pause_in[7:0] = in_byte; 5'd6: pause_in[15:8] = in_byte;
                  5'd7: dleft_in[7:0] = in_byte; 5'd8: dleft_in[15:8] = in_byte;
                  default: dleft_in[23:16] = in_byte;
               endcase
            end
            8'h15: begin
               case (idx_ff)
                  5'd0: zero_in[7:0] = in_byte;  5'd1: zero_in[15:8] = in_byte;
                  5'd2: pause_in[7:0] = in_byte; 5'd3: pause_in[15:8] = in_byte;
                  5'd4: fbits_in = tipg_pkg::norm_bits(in_byte);
                  5'd5: dleft_in[7:0] = in_byte; 5'd6: dleft_in[15:8] = in_byte;
                  default: dleft_in[23:16] = in_byte;
               endcase
            end
            8'h20: if (idx_ff[0]) pause_in[15:8] = in_byte; else pause_in[7:0] = in_byte;
            8'h21, 8'h30: sleft_in = {24'd0, in_byte};
            8'h31: if (idx_ff == 5'd1) sleft_in = {24'd0, in_byte};
            8'h32: if (idx_ff[0]) sleft_in[15:8] = in_byte; else sleft_in[7:0] = in_byte;
            8'h33: sleft_in = {22'd0, in_byte, 2'd0} - {22'd0, 2'd0, in_byte};
            8'h2A: case (idx_ff[1:0])
                  2'd0: sleft_in[7:0] = in_byte;   2'd1: sleft_in[15:8] = in_byte;
                  2'd2: sleft_in[23:16] = in_byte; default: sleft_in[31:24] = in_byte;
               endcase
            8'h2B: if (idx_ff == 5'd4) begin
                  c.level_en = 1'b1; c.level_high = (in_byte == 8'd1);
               end
            8'h35: if (idx_ff >= 5'd16) case (idx_ff[1:0])
                  2'd0: sleft_in[7:0] = in_byte;   2'd1: sleft_in[15:8] = in_byte;
                  2'd2: sleft_in[23:16] = in_byte; default: sleft_in[31:24] = in_byte;
               endcase
            default: ;
         endcase
         idx_in = ni;
         if (ni >= tipg_pkg::fields_len(kind_ff)) begin
            idx_in = '0;
            c.tone_t = pilot_t_in; c.tone_n = pcnt_in; c.sync1_t = s1_in;
            c.sync2_t = s2_in; c.pause_len = pause_in;
            kind_in = '0; ph_in = tipg_pkg::PH_FIELDS;
            case (kind_ff)
               8'h10: begin
                  kind_in = kind_ff;
                  ph_in = (dleft_in != 24'd0) ? tipg_pkg::PH_DATA : tipg_pkg::PH_PEEK;
               end
               8'h11, 8'h14, 8'h15: begin
                  if (kind_ff == 8'h11) begin
                     c.tone_en = (pcnt_in != 16'd0); c.sync_en = 1'b1;
                  end
                  if (dleft_in != 24'd0) begin
                     kind_in = kind_ff; ph_in = tipg_pkg::PH_DATA;
                  end else c.pause_en = (pause_in != 16'd0);
               end
               8'h12: c.tone_en = (pcnt_in != 16'd0);
               8'h13: if (seq_in != 8'd0) begin
                     kind_in = kind_ff; ph_in = tipg_pkg::PH_DATA;
                  end
               8'h20: begin
                  c.stop_en = (pause_in == 16'd0);
                  c.pause_en = (pause_in != 16'd0);
               end
               8'h2B: ;
               default: if (sleft_in != 32'd0) begin
                     kind_in = kind_ff; ph_in = tipg_pkg::PH_SKIP;
                  end else c.stop_en = (kind_ff == 8'h2A) && machine_is_48k;
            endcase
         end
      end
      if (in_eof) begin
         hdr_in = tipg_pkg::HEADER_SKIP; kind_in = '0; idx_in = '0; ph_in = tipg_pkg::PH_FIELDS;
         pilot_t_in = '0; s1_in = '0; s2_in = '0; zero_in = '0; one_in = '0; pcnt_in = '0;
         fbits_in = '0; pause_in = '0; dleft_in = '0; sleft_in = '0; low_in = '0; seq_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= tipg_pkg::HEADER_SKIP; kind_ff <= '0; idx_ff <= '0;
         ph_ff <= tipg_pkg::PH_FIELDS;
         pilot_t_ff <= '0; s1_ff <= '0; s2_ff <= '0; zero_ff <= '0; one_ff <= '0;
         pcnt_ff <= '0; fbits_ff <= '0; pause_ff <= '0; dleft_ff <= '0; sleft_ff <= '0;
         low_ff <= '0; seq_ff <= '0;
      end else if (fire) begin
         hdr_ff <= hdr_in; kind_ff <= kind_in; idx_ff <= idx_in; ph_ff <= ph_in;
         pilot_t_ff <= pilot_t_in; s1_ff <= s1_in; s2_ff <= s2_in; zero_ff <= zero_in;
         one_ff <= one_in; pcnt_ff <= pcnt_in; fbits_ff <= fbits_in; pause_ff <= pause_in;
         dleft_ff <= dleft_in; sleft_ff <= sleft_in; low_ff <= low_in; seq_ff <= seq_in;
      end
   end

endmodule
`default_nettype wire

[rtl/tipg_queue.sv]
// Short command queue between parser and emitter.
`timescale 1ns / 1ps
`default_nettype none
module tipg_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   output logic                   wr_ready,
   input  tipg_pkg::cmd_type      wr_cmd,
   output logic                   rd_valid,
   input  wire logic              rd_ready,
   output tipg_pkg::cmd_type      rd_cmd
);
   localparam int AW = $clog2(tipg_pkg::QDEPTH);

   tipg_pkg::cmd_type mem [tipg_pkg::QDEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          wr, rd;

   assign wr_ready = (cnt_ff != (AW+1)'(tipg_pkg::QDEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_cmd   = mem[rp_ff];
   assign wr = wr_valid & wr_ready;
   assign rd = rd_valid & rd_ready;
   assign wp_in  = wr ? wp_ff + AW'(1) : wp_ff;
   assign rp_in  = rd ? rp_ff + AW'(1) : rp_ff;
   assign cnt_in = cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem[wp_ff] <= wr_cmd;
   end
endmodule
`default_nettype wire

[rtl/tipg_emitter.sv]
// Back end: walks one command's steps into an output register, one result per cycle unless out_ready stalls it.
`timescale 1ns / 1ps
`default_nettype none
module tipg_emitter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  tipg_pkg::cmd_type      cmd,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [2:0]             out_action,
   output logic [25:0]            out_duration,
   output logic [15:0]            out_repeat,
   output logic                   out_last
);
   // step numbers
   localparam logic [4:0] S_LEAD = 5'd0, S_SYNC1 = 5'd1, S_SYNC2 = 5'd2, S_TONE = 5'd3;
   localparam logic [4:0] S_TS1 = 5'd4, S_TS2 = 5'd5, S_PULSE = 5'd6, S_BIT0 = 5'd7;
   localparam logic [4:0] S_PAUSE1 = 5'd15, S_PAUSE2 = 5'd16, S_LEVEL = 5'd17;
   localparam logic [4:0] S_STOP = 5'd18, S_ETOG = 5'd19, S_ESTOP = 5'd20;
   localparam int NSTEP = 21;

   logic [NSTEP-1:0] pend_ff, pend_in, req;
   logic             busy_ff, busy_in;
   tipg_pkg::cmd_type c_ff;
   logic             ov_ff;
   logic [2:0]       act_ff;
   logic [25:0]      dur_ff;
   logic [15:0]      rep_ff;
   logic             last_ff;
   logic [4:0]       sel;
   logic             found;
   logic [NSTEP-1:0] rest;
   logic [15:0]      t16;
   logic [25:0]      pms;
   logic             bitv;
   logic [2:0]       act_in;
   logic [25:0]      dur_in;
   logic [15:0]      rep_in;
   logic             can_out, step;

   // (2t+4)/7 by reciprocal: floor(x*37449>>18) then one correction
   function automatic logic [25:0] to_us(input logic [15:0] t);
      logic [17:0] x;
      logic [35:0] p;
      logic [17:0] q, r;
      x = {1'b0, t, 1'b0} + 18'd4;
      p = 36'(x) * 36'd37449;
      q = p[35:18];
      r = x - 18'(q * 18'd7);
      if (r >= 18'd7) q = q + 18'd1;
      to_us = 26'(q);
   endfunction

   always_comb begin
      req = '0;
      req[S_LEAD]  = cmd.lead_en;
      req[S_SYNC1] = cmd.lead_en;
      req[S_SYNC2] = cmd.lead_en;
      req[S_TONE]  = cmd.tone_en;
      req[S_TS1]   = cmd.sync_en;
      req[S_TS2]   = cmd.sync_en;
      req[S_PULSE] = cmd.pulse_en;
      for (int i = 0; i < 8; i++) req[S_BIT0 + i] = (4'(i) < cmd.nbits);
      req[S_PAUSE1] = cmd.pause_en;
      req[S_PAUSE2] = cmd.pause_en;
      req[S_LEVEL]  = cmd.level_en;
      req[S_STOP]   = cmd.stop_en;
      req[S_ETOG]   = cmd.eof & ~cmd.stop_en;
      req[S_ESTOP]  = cmd.eof & ~cmd.stop_en;
   end

   assign can_out = ~ov_ff | out_ready;

   always_comb begin
      sel = '0; found = 1'b0;
      for (int i = NSTEP - 1; i >= 0; i--) if (pend_ff[i]) begin sel = 5'(i); found = 1'b1; end
      rest = pend_ff;
      rest[sel] = 1'b0;
      bitv = c_ff.data[3'd7 - 3'(sel - S_BIT0)];
      t16 = c_ff.zero_t;
      act_in = tipg_pkg::ACT_TOGGLE; rep_in = 16'd1; dur_in = '0;
      pms = 26'(({10'd0, c_ff.pause_len} - 26'd1) * 26'd1000);
      case (sel)
         S_LEAD:  begin dur_in = 26'd619; rep_in = c_ff.lead_long ? 16'd8063 : 16'd3223; end
         S_SYNC1: dur_in = 26'd191;
         S_SYNC2: dur_in = 26'd210;
         S_TONE:  begin t16 = c_ff.tone_t; rep_in = c_ff.tone_n; end
         S_TS1:   t16 = c_ff.sync1_t;
         S_TS2:   t16 = c_ff.sync2_t;
         S_PULSE: t16 = c_ff.pulse_t;
         S_PAUSE1: dur_in = 26'd1000;
         S_PAUSE2: begin act_in = tipg_pkg::ACT_LOW; dur_in = pms; end
         S_LEVEL: act_in = c_ff.level_high ? tipg_pkg::ACT_HIGH : tipg_pkg::ACT_LOW;
         S_STOP, S_ESTOP: act_in = tipg_pkg::ACT_STOP;
         S_ETOG: ;
         default: begin
            case (c_ff.bit_mode)
               tipg_pkg::BM_STD: begin
                  dur_in = bitv ? 26'd489 : 26'd244; rep_in = 16'd2;
               end
               tipg_pkg::BM_DIRECT: begin
                  act_in = bitv ? tipg_pkg::ACT_HIGH : tipg_pkg::ACT_LOW;
               end
               default: begin
                  t16 = bitv ? c_ff.one_t : c_ff.zero_t; rep_in = 16'd2;
               end
            endcase
         end
      endcase
      if (sel == S_TONE || sel == S_TS1 || sel == S_TS2 || sel == S_PULSE ||
          (sel >= S_BIT0 && sel < S_PAUSE1 && c_ff.bit_mode != tipg_pkg::BM_STD))
         dur_in = to_us(t16);
   end

   assign step = busy_ff & found & can_out;
   assign cmd_ready = ~busy_ff | (step & (rest == '0)) | (busy_ff & ~found);

   always_comb begin
      busy_in = busy_ff; pend_in = pend_ff;
      if (step) pend_in = rest;
      if (busy_ff & (step & (rest == '0) | ~found)) busy_in = 1'b0;
      if (cmd_valid & cmd_ready) begin
         busy_in = 1'b1; pend_in = req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; pend_ff <= '0; ov_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; pend_ff <= pend_in;
         if (step) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid & cmd_ready) c_ff <= cmd;
      if (step) begin
         act_ff <= act_in; dur_ff <= dur_in; rep_ff <= rep_in; last_ff <= (rest == '0);
      end
   end

   assign out_valid    = ov_ff;
   assign out_action   = act_ff;
   assign out_duration = dur_ff;
   assign out_repeat   = rep_ff;
   assign out_last     = last_ff;
endmodule
`default_nettype wire

[rtl/tape_image_pulse_generator_core.sv]
// Top level: tape image byte parser, command queue and pulse command emitter.
// A byte's command passes through the queue, the emitter's command register and its output register.
// Throughput: one result per cycle while rsp_ready does not stall the output, and the parser
// takes a byte every cycle while the queue has room.
// Reset: synchronous, active high; clears parse state, the queue, the emitter and the 48k register.
`timescale 1ns / 1ps
`default_nettype none
module tape_image_pulse_generator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_machine_is_48k,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_file_byte,
   input  wire logic        req_end_of_file,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_action,
   output logic [25:0]      rsp_duration_us,
   output logic [15:0]      rsp_repeat_res,
   output logic             rsp_last
);
   logic m48_ff;
   logic pq_valid, pq_ready, qe_valid, qe_ready;
   tipg_pkg::cmd_type pq_cmd, qe_cmd;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) m48_ff <= 1'b0;
      else if (csr_valid) m48_ff <= csr_machine_is_48k;
   end

   tipg_parser u_parser (
      .clock, .reset, .machine_is_48k(m48_ff),
      .in_valid(req_valid), .in_ready(req_ready), .in_byte(req_file_byte),
      .in_eof(req_end_of_file),
      .cmd_valid(pq_valid), .cmd_ready(pq_ready), .cmd(pq_cmd));

   tipg_queue u_queue (
      .clock, .reset, .wr_valid(pq_valid), .wr_ready(pq_ready), .wr_cmd(pq_cmd),
      .rd_valid(qe_valid), .rd_ready(qe_ready), .rd_cmd(qe_cmd));

   tipg_emitter u_emitter (
      .clock, .reset, .cmd_valid(qe_valid), .cmd_ready(qe_ready), .cmd(qe_cmd),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_action(rsp_action),
      .out_duration(rsp_duration_us), .out_repeat(rsp_repeat_res), .out_last(rsp_last));

   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_action == tipg_pkg::ACT_TOGGLE || rsp_action == tipg_pkg::ACT_HIGH ||
                     rsp_action == tipg_pkg::ACT_LOW || rsp_action == tipg_pkg::ACT_STOP))
      else $error("bad action");
   a_repeat_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_res != 16'd0) else $error("zero repeat");
   a_stop_nodur: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == tipg_pkg::ACT_STOP |-> rsp_duration_us == 26'd0)
      else $error("stop with duration");
endmodule
`default_nettype wire
